@@ hdl/fsa_pkg.sv @@
// fraction sum accumulator: shared types and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int InW    = 16;
  localparam int SumW   = 32;
  localparam int ProdW  = SumW + InW;
  localparam int AccW   = ProdW + 1;
  localparam int SumCntW = $clog2(SumW);

  typedef struct packed {
    logic signed [InW-1:0] numerator;
    logic signed [InW-1:0] denominator;
    logic                  first;
  } in_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum_numerator;
    logic signed [SumW-1:0] sum_denominator;
    logic                   overflow;
    logic                   zero_fraction;
  } out_t;

  // request into the reduction unit
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] num;
    logic [SumW-1:0] den;
  } red_req_t;

  // response from the reduction unit
  typedef struct packed {
    logic            done;
    logic            zero;
    logic [SumW-1:0] num;
    logic [SumW-1:0] den;
  } red_rsp_t;

endpackage

@@ hdl/fraction_sum_accumulator_core.sv @@
// fraction sum accumulator: top level with handshake, sequencer and running sum
// depends on fsa_pkg, fsa_mul and fsa_reduce
`timescale 1ns / 1ps

// usage
//   input channel in_valid / in_ready / in_data carries one signed fraction per
//   item plus a first flag; the result channel out_valid / out_ready / out_data
//   returns the running sum after every item with overflow and zero flags
//   an item with first set loads the fraction as the sum with no reduction:
//   the result goes through the finishing state to the output register
//   any other item runs three products on one 32x16 multiplier, a saturation
//   step, then the reduction unit: a binary gcd whose length depends on the
//   operand bits, and two restoring divisions, all on one shared subtractor;
//   a 0/0 sum skips the divisions
//   in_ready is high only while the sequencer is idle, one item at a time
//   the result sits in an output register; the next item is taken while it
//   waits, and a finished item holds in the sequencer until that register frees
//   reset (rst_n low, synchronous) empties the output register and sets the
//   running sum to 0/1

module fraction_sum_accumulator_core
  import fsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_AD,
    S_MUL_NB,
    S_MUL_BD,
    S_SAT,
    S_START,
    S_RED,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  in_t                    item_r, item_nxt;
  logic [SumW-1:0]        run_num_r, run_num_nxt;
  logic [SumW-1:0]        run_den_r, run_den_nxt;
  logic signed [AccW-1:0] t_acc_r, t_acc_nxt;
  logic [SumW-1:0]        sat_num_r, sat_num_nxt;
  logic [SumW-1:0]        sat_den_r, sat_den_nxt;
  logic                   ovf_r, ovf_nxt;
  out_t                   res_r, res_nxt;
  out_t                   out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic signed [SumW-1:0]  mul_a;
  logic signed [InW-1:0]   mul_b;
  logic signed [ProdW-1:0] prod;
  red_req_t                red_req;
  red_rsp_t                red_rsp;

  logic                    t_ovf, m_ovf;
  logic [SumW-1:0]         t_sat, m_sat;
  logic                    out_free;

  // saturate a wide signed value to the 32-bit range
  function automatic logic [SumW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v[AccW-1:SumW-1] == '0 || v[AccW-1:SumW-1] == '1) begin
      sat32 = v[SumW-1:0];
    end else if (v[AccW-1]) begin
      sat32 = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(SumW-1){1'b1}}};
    end
  endfunction

  function automatic logic fits32(input logic signed [AccW-1:0] v);
    fits32 = (v[AccW-1:SumW-1] == '0) || (v[AccW-1:SumW-1] == '1);
  endfunction

  // operand select for the shared multiplier: sum_num*d, sum_den*n, sum_den*d
  always_comb begin
    mul_a = run_den_r;
    mul_b = item_r.denominator;
    case (state_r)
      S_MUL_AD: begin
        mul_a = run_num_r;
        mul_b = item_r.denominator;
      end
      S_MUL_NB: begin
        mul_a = run_den_r;
        mul_b = item_r.numerator;
      end
      default: begin
        mul_a = run_den_r;
        mul_b = item_r.denominator;
      end
    endcase
  end

  fsa_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  assign red_req.start = (state_r == S_START);
  assign red_req.num   = sat_num_r;
  assign red_req.den   = sat_den_r;

  fsa_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .rsp   (red_rsp)
  );

  // in S_SAT the multiplier holds sum_den*d and t_acc_r the cross sum
  assign t_sat = sat32(t_acc_r);
  assign t_ovf = !fits32(t_acc_r);
  assign m_sat = sat32(AccW'(prod));
  assign m_ovf = !fits32(AccW'(prod));

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    run_num_nxt   = run_num_r;
    run_den_nxt   = run_den_r;
    t_acc_nxt     = t_acc_r;
    sat_num_nxt   = sat_num_r;
    sat_den_nxt   = sat_den_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.first) begin
            // load: sign-extended, no reduction, no flags
            res_nxt.sum_numerator   = SumW'(in_data.numerator);
            res_nxt.sum_denominator = SumW'(in_data.denominator);
            res_nxt.overflow        = 1'b0;
            res_nxt.zero_fraction   = 1'b0;
            state_nxt               = S_FIN;
          end else begin
            state_nxt = S_MUL_AD;
          end
        end
      end
      S_MUL_AD: state_nxt = S_MUL_NB;
      S_MUL_NB: begin
        t_acc_nxt = AccW'(prod);
        state_nxt = S_MUL_BD;
      end
      S_MUL_BD: begin
        t_acc_nxt = t_acc_r + AccW'(prod);
        state_nxt = S_SAT;
      end
      S_SAT: begin
        sat_num_nxt = t_sat;
        sat_den_nxt = m_sat;
        ovf_nxt     = t_ovf || m_ovf;
        state_nxt   = S_START;
      end
      S_START: state_nxt = S_RED;
      S_RED: begin
        if (red_rsp.done) begin
          res_nxt.sum_numerator   = red_rsp.num;
          res_nxt.sum_denominator = red_rsp.den;
          res_nxt.overflow        = ovf_r;
          res_nxt.zero_fraction   = red_rsp.zero;
          state_nxt               = S_FIN;
        end
      end
      S_FIN: begin
        // hand the item to the output register once it is free
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          run_num_nxt   = res_r.sum_numerator;
          run_den_nxt   = res_r.sum_denominator;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      run_num_r   <= '0;
      run_den_r   <= SumW'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_num_r   <= run_num_nxt;
      run_den_r   <= run_den_nxt;
    end
    item_r    <= item_nxt;
    t_acc_r   <= t_acc_nxt;
    sat_num_r <= sat_num_nxt;
    sat_den_r <= sat_den_nxt;
    ovf_r     <= ovf_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a zero flag means the sum really is 0/0
  a_zero_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_fraction |->
      out_data.sum_numerator == '0 && out_data.sum_denominator == '0)
    else $error("zero flag on a nonzero sum");

  // saturation leaves a nonzero part, so both flags never stand together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.zero_fraction && out_data.overflow))
    else $error("overflow and zero flags together");

  // the reduction unit answers only while the sequencer waits for it
  a_done_in_red: assert property (@(posedge clk) disable iff (!rst_n)
    red_rsp.done |-> state_r == S_RED)
    else $error("reduction done outside the wait state");

  // a new result appears only from the finishing state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the finishing state");

endmodule

@@ hdl/fsa_mul.sv @@
// fraction sum accumulator: registered signed 32x16 multiplier
// depends on fsa_pkg
`timescale 1ns / 1ps

module fsa_mul
  import fsa_pkg::*;
(
  input  logic                    clk,
  input  logic signed [SumW-1:0]  op_a,
  input  logic signed [InW-1:0]   op_b,
  output logic signed [ProdW-1:0] prod_r
);

  logic signed [ProdW-1:0] prod_nxt;

  assign prod_nxt = ProdW'(op_a) * ProdW'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

@@ hdl/fsa_reduce.sv @@
// fraction sum accumulator: gcd reduction unit
// binary gcd then two restoring divisions, all on one shared subtractor
// depends on fsa_pkg
`timescale 1ns / 1ps

module fsa_reduce
  import fsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  red_req_t req,
  output red_rsp_t rsp
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIVN,
    R_DIVD
  } rstate_t;

  rstate_t              state_r, state_nxt;
  logic [SumW-1:0]      u_r, u_nxt, v_r, v_nxt;
  logic [SumCntW-1:0]   k_r, k_nxt;
  logic [SumW-1:0]      g_r, g_nxt;
  logic [SumW-1:0]      x_r, x_nxt, rem_r, rem_nxt;
  logic [SumCntW-1:0]   cnt_r, cnt_nxt;
  logic [SumW-1:0]      num_in_r, num_in_nxt, den_in_r, den_in_nxt;
  red_rsp_t             rsp_r, rsp_nxt;

  logic [SumW-1:0]      sub_a, sub_b;
  logic [SumW:0]        diff;
  logic                 borrow;
  logic [SumW-1:0]      rem_sh;
  logic                 qbit;
  logic [SumW-1:0]      quo;

  function automatic logic [SumW-1:0] mag(input logic [SumW-1:0] v);
    mag = v[SumW-1] ? SumW'(0) - v : v;
  endfunction

  // the one subtractor: gcd compare/subtract or divide trial subtract
  assign rem_sh = {rem_r[SumW-2:0], x_r[SumW-1]};
  assign sub_a  = (state_r == R_GCD) ? u_r : rem_sh;
  assign sub_b  = (state_r == R_GCD) ? v_r : g_r;
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[SumW];
  assign qbit   = !borrow;
  assign quo    = {x_r[SumW-2:0], qbit};

  always_comb begin
    state_nxt  = state_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    k_nxt      = k_r;
    g_nxt      = g_r;
    x_nxt      = x_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    num_in_nxt = num_in_r;
    den_in_nxt = den_in_r;
    rsp_nxt    = rsp_r;
    rsp_nxt.done = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          num_in_nxt = req.num;
          den_in_nxt = req.den;
          u_nxt      = mag(req.num);
          v_nxt      = mag(req.den);
          k_nxt      = '0;
          state_nxt  = R_GCD;
        end
      end
      R_GCD: begin
        if (u_r == '0 && v_r == '0) begin
          // 0/0: nothing to divide by
          rsp_nxt.done = 1'b1;
          rsp_nxt.zero = 1'b1;
          rsp_nxt.num  = num_in_r;
          rsp_nxt.den  = den_in_r;
          state_nxt    = R_IDLE;
        end else if (u_r == '0 || v_r == '0) begin
          g_nxt     = (u_r == '0) ? (v_r << k_r) : (u_r << k_r);
          x_nxt     = mag(num_in_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = R_DIVN;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + SumCntW'(1);
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (borrow) begin
          // keep u >= v so the subtractor runs one way only
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          u_nxt = diff[SumW-1:0] >> 1;
        end
      end
      R_DIVN, R_DIVD: begin
        rem_nxt = borrow ? rem_sh : diff[SumW-1:0];
        x_nxt   = quo;
        cnt_nxt = cnt_r + SumCntW'(1);
        if (cnt_r == SumCntW'(SumW - 1)) begin
          if (state_r == R_DIVN) begin
            rsp_nxt.num = num_in_r[SumW-1] ? SumW'(0) - quo : quo;
            x_nxt       = mag(den_in_r);
            rem_nxt     = '0;
            cnt_nxt     = '0;
            state_nxt   = R_DIVD;
          end else begin
            rsp_nxt.den  = den_in_r[SumW-1] ? SumW'(0) - quo : quo;
            rsp_nxt.zero = 1'b0;
            rsp_nxt.done = 1'b1;
            state_nxt    = R_IDLE;
          end
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= R_IDLE;
      rsp_r.done   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rsp_r.done   <= rsp_nxt.done;
    end
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    k_r      <= k_nxt;
    g_r      <= g_nxt;
    x_r      <= x_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    num_in_r <= num_in_nxt;
    den_in_r <= den_in_nxt;
    rsp_r.zero <= rsp_nxt.zero;
    rsp_r.num  <= rsp_nxt.num;
    rsp_r.den  <= rsp_nxt.den;
  end

  assign rsp = rsp_r;

endmodule

@@ test/fsa_checker.sv @@
// fraction sum checker: watches both channels of the accumulator, keeps its own
// copy of the running sum and compares every returned sum; depends on fsa_pkg
`timescale 1ns / 1ps

module fsa_checker
  import fsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   sums_checked,
  output int   saturations,
  output int   zero_sums
);

  logic [SumW-1:0] acc_num;
  logic [SumW-1:0] acc_den;
  out_t            expected_sums[$];
  int              mismatches;
  int              checked;
  int              sat_count;
  int              zero_count;

  function automatic logic [SumW-1:0] clamp_sum(input longint v, inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[SumW-1:0];
  endfunction

  function automatic logic [SumW-1:0] abs_sum(input logic [SumW-1:0] v);
    return v[SumW-1] ? 32'd0 - v : v;
  endfunction

  function automatic logic [SumW-1:0] gcd_of(input logic [SumW-1:0] a,
                                             input logic [SumW-1:0] b);
    logic [SumW-1:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // exact division keeps the sign of the dividend
  function automatic logic [SumW-1:0] cancel(input logic [SumW-1:0] v,
                                             input logic [SumW-1:0] g);
    logic [SumW-1:0] q;
    q = abs_sum(v) / g;
    return v[SumW-1] ? 32'd0 - q : q;
  endfunction

  // advances the running sum by one item and returns the sum it reports
  function automatic out_t fold_fraction(input in_t item);
    out_t            res;
    longint          a;
    longint          b;
    longint          n;
    longint          d;
    logic [SumW-1:0] tn;
    logic [SumW-1:0] td;
    logic [SumW-1:0] g;
    logic            ovf;
    res = '0;
    ovf = 1'b0;
    n   = longint'(item.numerator);
    d   = longint'(item.denominator);
    if (item.first) begin
      // load as given, no reduction, no flags even for 0/0
      acc_num = n[SumW-1:0];
      acc_den = d[SumW-1:0];
    end else begin
      a  = longint'($signed(acc_num));
      b  = longint'($signed(acc_den));
      tn = clamp_sum(a * d + n * b, ovf);
      td = clamp_sum(b * d, ovf);
      g  = gcd_of(abs_sum(tn), abs_sum(td));
      if (g == 0) begin
        res.zero_fraction = 1'b1;
      end else begin
        tn = cancel(tn, g);
        td = cancel(td, g);
      end
      acc_num = tn;
      acc_den = td;
    end
    res.sum_numerator   = acc_num;
    res.sum_denominator = acc_den;
    res.overflow        = ovf;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [SumW-1:0] want,
                             input logic [SumW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      acc_num = '0;
      acc_den = 32'd1;
      expected_sums.delete();
    end else begin
      // results first so a sum never meets the item taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("sum returned with no item outstanding: %0d/%0d",
                 $signed(out_data.sum_numerator), $signed(out_data.sum_denominator));
          mismatches++;
        end else begin
          want = expected_sums.pop_front();
          check_field("sum_numerator", want.sum_numerator, out_data.sum_numerator);
          check_field("sum_denominator", want.sum_denominator, out_data.sum_denominator);
          check_field("overflow", SumW'(want.overflow), SumW'(out_data.overflow));
          check_field("zero_fraction", SumW'(want.zero_fraction),
                      SumW'(out_data.zero_fraction));
          checked++;
          if (want.overflow) sat_count++;
          if (want.zero_fraction) zero_count++;
        end
      end
      if (in_valid && in_ready) expected_sums.push_back(fold_fraction(in_data));
    end
    fail_count   <= mismatches;
    pending      <= expected_sums.size();
    sums_checked <= checked;
    saturations  <= sat_count;
    zero_sums    <= zero_count;
  end

endmodule

@@ test/tb_top.sv @@
// testbench top for the fraction sum accumulator: clock, reset, item stimulus,
// output stalls and verdict; depends on fsa_pkg, fsa_checker and the core
`timescale 1ns / 1ps

module tb_top
  import fsa_pkg::*;
;

  localparam int LongHold    = 700;    // output stall that backs the block up
  localparam int MainItems   = 1170;   // items sent with idling on both sides
  localparam int TailItems   = 180;    // items sent with no idling at all
  localparam int TailCycles  = 300;    // settle time past the slowest item
  localparam int DrainLimit  = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int   fail_count;
  int   pending;
  int   sums_checked;
  int   saturations;
  int   zero_sums;

  logic idle_on;          // random idling on both channels
  logic long_hold_req;    // ask the output side for one long stall
  logic long_hold_done;
  int   items_sent;
  int   loads_sent;

  fraction_sum_accumulator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fsa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .sums_checked (sums_checked),
    .saturations  (saturations),
    .zero_sums    (zero_sums)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("timeout: %0d items sent, %0d sums still outstanding", items_sent, pending);
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stall bursts, one long stall on request, none when idling is off
  initial begin : sink
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        out_ready <= 1'b1;
        long_hold_done = 1'b1;
      end else if (!idle_on) begin
        out_ready <= 1'b1;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          // about one run in three starts with a stall burst
          stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
          run_left   = $urandom_range(1, 40);
        end
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  function automatic in_t frac(input int num, input int den, input logic first);
    in_t item;
    item.numerator   = num[InW-1:0];
    item.denominator = den[InW-1:0];
    item.first       = first;
    return item;
  endfunction

  // mostly small parts so sums stay reducible, plus full range and the extremes
  function automatic logic [InW-1:0] pick_part();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $urandom_range(0, 40) - 20;
    end else if (sel < 6) begin
      v = $urandom_range(0, 600) - 300;
    end else if (sel < 9) begin
      v = $urandom();
    end else begin
      case ($urandom_range(0, 4))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = 0;
        3:       v = 1;
        default: v = -1;
      endcase
    end
    return v[InW-1:0];
  endfunction

  function automatic in_t random_frac(input logic first);
    in_t item;
    item.numerator   = pick_part();
    item.denominator = pick_part();
    item.first       = first;
    return item;
  endfunction

  // offer one item, hold it until taken, then maybe leave a gap; valid stays
  // high after the accept unless a gap follows, so back-to-back items never
  // lower and raise it in the same step
  task automatic feed(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (item.first) loads_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every sum has come back; pending is registered in the checker, so it lags the queue
  task automatic drain(input int bound);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < bound);
  endtask

  initial begin : stimulus
    int run_len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    items_sent    = 0;
    loads_sent    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 0/0 load carries no flags, then adds onto 0/0 stay 0/0
    feed(frac(0, 0, 1'b1));
    feed(frac(0, 0, 1'b0));
    feed(frac(5, 3, 1'b0));
    // zero numerator reduces to 0 over unit
    feed(frac(1, 2, 1'b1));
    feed(frac(-1, 2, 1'b0));
    // zero denominator reduces to unit over 0, both signs
    feed(frac(3, 0, 1'b1));
    feed(frac(1, 5, 1'b0));
    feed(frac(-3, 0, 1'b1));
    feed(frac(1, 5, 1'b0));
    // denominator sign kept, then a zero denominator item added
    feed(frac(1, -2, 1'b1));
    feed(frac(1, 3, 1'b0));
    feed(frac(7, 0, 1'b0));
    // field extremes
    feed(frac(32767, -32768, 1'b1));
    feed(frac(-32768, 32767, 1'b0));
    // growing denominator saturates positive
    feed(frac(1, 32767, 1'b1));
    feed(frac(1, 32766, 1'b0));
    feed(frac(1, 32765, 1'b0));
    // and negative
    feed(frac(1, -32767, 1'b1));
    feed(frac(1, 32766, 1'b0));
    feed(frac(1, 32765, 1'b0));
    feed(frac(-32768, 1, 1'b1));
    feed(frac(-32768, 1, 1'b0));
    feed(frac(-32768, -32768, 1'b0));
    // sender pauses until the block is empty
    drain(DrainLimit);

    // random runs: a load followed by adds, with stray loads and runs that
    // keep the previous sum as noise
    while (items_sent < MainItems) begin
      if (!long_hold_req && items_sent > 500) long_hold_req <= 1'b1;
      if (items_sent > 900 && items_sent < 915) drain(DrainLimit);
      run_len = $urandom_range(1, 12);
      if ($urandom_range(0, 9) != 0) feed(random_frac(1'b1));
      repeat (run_len) feed(random_frac($urandom_range(0, 19) == 0));
    end

    // the last part runs with no idling on either side
    drain(DrainLimit);
    while (!long_hold_done) @(posedge clk);
    idle_on <= 1'b0;
    @(posedge clk);
    while (items_sent < MainItems + TailItems) begin
      if ($urandom_range(0, 5) == 0) feed(random_frac(1'b1));
      else feed(random_frac(1'b0));
    end

    drain(DrainLimit);
    repeat (TailCycles) @(posedge clk);
    if (pending != 0) $error("%0d expected sums never arrived", pending);
    $display("ran %0d items (%0d loads) and checked %0d sums, %0d saturated, %0d at 0/0",
             items_sent, loads_sent, sums_checked, saturations, zero_sums);
    $display("included random stalls on both sides, one long output stall and an idle-free tail");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
